[src/spmv_pkg.sv]
// Shared types and constants for the sparse matrix-vector multiplier.
package spmv_pkg;

    localparam int COLUMN_BITS  = 12;
    localparam int RAW_BITS     = 32;
    localparam int SUM_BITS     = 64;
    localparam int ROW_BITS     = 20;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_ACCUM  = 1'b1;

    typedef struct packed {
        logic                       command;
        logic [COLUMN_BITS-1:0]     column;
        logic signed [RAW_BITS-1:0] element_value;
        logic                       last_in_row;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] row_sum;
        logic [ROW_BITS-1:0]        row_number;
        logic                       overflow;
    } t_out_item;

endpackage

[src/sparse_matrix_vector_multiply.sv]
// Top level of the sparse matrix-vector multiplier (y = A*x, rows in order).
//
// Send the vector first as write beats (command write, column = index), then
// the matrix row by row, one accumulate beat per nonzero element; flag the
// last element of each row, and send an empty row as one zero-valued element
// with the flag set. Every flagged element yields one result beat holding the
// Q32.32 row sum (saturated at the 64-bit limits), the wrapping row number and
// a sticky overflow flag. The block takes one beat per cycle while o_stall is
// low; a row result passes the vector store read register, the product
// register and the output register that the saturating add feeds before it
// is presented. A stall on the result side while a result waits holds the
// whole pipeline, so input stall follows it. Writes to columns at or beyond
// VECTOR_DEPTH are dropped and elements there read x as zero. Reading a
// vector entry never written since reset gives an undefined product. Values
// use the low VALUE_BITS bits, sign-extended.
module sparse_matrix_vector_multiply #(
    parameter int VECTOR_DEPTH = 4096,
    parameter int VALUE_BITS   = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  spmv_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output spmv_pkg::t_out_item o_data
);

    localparam int ADDR_BITS = $clog2(VECTOR_DEPTH);
    localparam int PROD_BITS = 2 * VALUE_BITS;

    logic                  en;
    logic                  accept;
    logic [31:0]           col_wide;
    logic                  in_range;
    logic [ADDR_BITS-1:0]  addr;
    logic [VALUE_BITS-1:0] rd_data;

    // element stage 1: waiting on the vector read
    logic                         r_s1_valid;
    logic                         r_s1_in_range;
    logic                         r_s1_last;
    logic signed [VALUE_BITS-1:0] r_s1_a;

    // element stage 2: product registered
    logic                         r_s2_valid;
    logic                         r_s2_last;
    logic signed [PROD_BITS-1:0]  r_s2_prod;
    logic signed [VALUE_BITS-1:0] x_val;

    logic                 done;
    spmv_pkg::t_out_item  result;
    logic                 r_out_valid, n_out_valid;
    spmv_pkg::t_out_item  r_out;

    // advance everything unless a finished result is held back
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;
    assign accept  = i_valid && en;

    assign col_wide = 32'(i_data.column);
    assign in_range = col_wide < 32'(VECTOR_DEPTH);
    assign addr     = col_wide[ADDR_BITS-1:0];

    spmv_vec_mem #(
        .DEPTH (VECTOR_DEPTH),
        .WIDTH (VALUE_BITS)
    ) u_vec_mem (
        .i_clk     (i_clk),
        .i_wr_en   (accept && i_data.command == spmv_pkg::CMD_WRITE && in_range),
        .i_wr_addr (addr),
        .i_wr_data (i_data.element_value[VALUE_BITS-1:0]),
        .i_rd_en   (accept && i_data.command == spmv_pkg::CMD_ACCUM && in_range),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept && i_data.command == spmv_pkg::CMD_ACCUM;
            r_s2_valid <= r_s1_valid;
        end
    end

    // columns beyond the store contribute zero
    assign x_val = r_s1_in_range ? $signed(rd_data) : '0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_in_range <= in_range;
            r_s1_last     <= i_data.last_in_row;
            r_s1_a        <= $signed(i_data.element_value[VALUE_BITS-1:0]);
            r_s2_last     <= r_s1_last;
            r_s2_prod     <= r_s1_a * x_val;
        end
    end

    spmv_accum #(
        .PROD_BITS (PROD_BITS)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_s2_valid),
        .i_last    (r_s2_last),
        .i_product (r_s2_prod),
        .o_done    (done),
        .o_result  (result)
    );

    // output register: load on a finished row, drop once the beat is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (done) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[src/spmv_vec_mem.sv]
// Vector store: one write port, one read port with registered read data.
module spmv_vec_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/spmv_accum.sv]
// Saturating row accumulator with row counter and sticky overflow flag.
module spmv_accum #(
    parameter int PROD_BITS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic                        i_last,
    input  logic signed [PROD_BITS-1:0] i_product,
    output logic                        o_done,
    output spmv_pkg::t_out_item         o_result
);

    localparam int SB = spmv_pkg::SUM_BITS;

    logic signed [SB-1:0]            r_acc, n_acc;
    logic                            r_sat, n_sat;
    logic [spmv_pkg::ROW_BITS-1:0]   r_row, n_row;
    logic signed [SB-1:0]            prod_ext;
    logic signed [SB:0]              wide;
    logic                            ovf;
    logic signed [SB-1:0]            sum;

    always_comb begin
        prod_ext = SB'(i_product);
        wide     = {r_acc[SB-1], r_acc} + {prod_ext[SB-1], prod_ext};
        ovf      = wide[SB] != wide[SB-1];
        // clamp toward the sign of the true result
        if (ovf) begin
            sum = wide[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end else begin
            sum = wide[SB-1:0];
        end

        o_done              = i_en && i_valid && i_last;
        o_result.row_sum    = sum;
        o_result.row_number = r_row;
        o_result.overflow   = r_sat || ovf;

        n_acc = r_acc;
        n_sat = r_sat;
        n_row = r_row;
        if (i_en && i_valid) begin
            if (i_last) begin
                n_acc = '0;
                n_sat = 1'b0;
                n_row = r_row + 1'b1;
            end else begin
                n_acc = sum;
                n_sat = r_sat || ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_sat <= 1'b0;
            r_row <= '0;
        end else begin
            r_acc <= n_acc;
            r_sat <= n_sat;
            r_row <= n_row;
        end
    end

endmodule
